// File: rtl/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg: shared types and constants of the windowed sample filter
// Sample format, filter mode codes and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package wsf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int HELD_W     = 5;
    localparam int MODE_W     = 2;
    localparam int MEDIAN_MIN = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [MODE_W-1:0]          mode_t;

    // filter mode codes; the unused code behaves as the mean
    localparam mode_t MODE_MEAN     = 2'd0;
    localparam mode_t MODE_MEDIAN   = 2'd1;
    localparam mode_t MODE_WEIGHTED = 2'd2;
    localparam mode_t MODE_RESET    = MODE_MEDIAN;

    // control from the sequencer to every cell
    typedef struct packed {
        logic shift;   // take a new sample in, age the window
        logic load;    // copy the window into the scan ring
        logic rotate;  // step the scan ring by one cell
    } cell_ctrl_t;

endpackage : wsf_pkg

`default_nettype wire

// File: rtl/wsf_cell.sv
// ----------------------------------------------------------------------------
// wsf_cell: one window cell
// Holds one sample of the window and one scan ring entry, and compares its
// sample against the candidate broadcast along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_cell
    import wsf_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       held,
    input  wire sample_t    win_in,
    output sample_t         win_out,
    input  wire sample_t    scan_in,
    output sample_t         scan_out,
    input  wire sample_t    cand,
    output logic            lt,
    output logic            le
);

    sample_t win_reg;
    sample_t scan_reg;

    // window and scan registers; payload only, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            win_reg <= win_in;
        end
        if (ctrl.load)
        begin
            scan_reg <= win_reg;
        end
        else if (ctrl.rotate)
        begin
            scan_reg <= scan_in;
        end
    end

    // rank compares against the candidate
    assign lt       = held && (win_reg < cand);
    assign le       = held && (win_reg <= cand);
    assign win_out  = win_reg;
    assign scan_out = scan_reg;

endmodule : wsf_cell

`default_nettype wire

// File: rtl/wsf_div.sv
// ----------------------------------------------------------------------------
// wsf_div: iterative signed divider
// Restoring division of a signed dividend by a positive divisor, one
// quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_div
    import wsf_pkg::*;
#(
    parameter int A_W = 36,
    parameter int D_W = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [A_W-1:0] dividend,
    input  wire logic [D_W-1:0]        divisor,
    output logic                       busy,
    output logic                       done,
    output logic signed [A_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(A_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [A_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     rem_sub;
    logic             fits;

    // one restoring step
    assign rem_sh  = {rem_reg, quo_reg[A_W-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign fits    = (rem_sh >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(A_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitudes in, sign restored on the way out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[A_W-1];
            quo_reg <= dividend[A_W-1] ? A_W'(-dividend) : A_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
            quo_reg <= {quo_reg[A_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule : wsf_div

`default_nettype wire

// File: rtl/windowed_sample_filter.sv
// ----------------------------------------------------------------------------
// windowed_sample_filter: mean, median or weighted mean over a sample window
// Window held in a chain of cells; a scan ring walks it for rank and weights.
// ----------------------------------------------------------------------------
// Path, accept edge to output register: median with fewer than three held goes
//   straight there; median walks the scan ring; mean runs the one-bit-a-cycle
//   divider; weighted mean walks the scan ring, then runs the divider.
// Throughput: one item at a time; the next is taken the cycle after the result
//   is in the output register. Reset: window empty, mode median, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_sample_filter
    import wsf_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [MODE_W-1:0]   cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [23:0]  sample,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [23:0]       filtered_value,
    output logic [HELD_W-1:0]        samples_held
);

    localparam int N_W   = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int TOT_W = $clog2(WINDOW * (WINDOW + 1) / 2 + 1);
    localparam int ACC_W = SAMPLE_W + TOT_W + 1;

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_SCAN, ST_DIV, ST_DONE} state_t;

    state_t             state_reg;
    mode_t              mode_reg;
    mode_t              cur_mode_reg;
    logic [N_W-1:0]     fill_reg;
    logic [N_W-1:0]     fill_next;
    logic [N_W-1:0]     t_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    sample_t            res_reg;
    logic               found_reg;
    logic               out_valid_reg;
    sample_t            out_val_reg;
    logic [HELD_W-1:0]  out_held_reg;

    cell_ctrl_t         ctrl;
    sample_t            win  [WINDOW];
    sample_t            scan [WINDOW];
    logic [WINDOW-1:0]  lt_vec;
    logic [WINDOW-1:0]  le_vec;
    logic [WINDOW-1:0]  held_vec;
    sample_t            cand;
    logic [N_W-1:0]     lt_cnt;
    logic [N_W-1:0]     le_cnt;
    logic [N_W-1:0]     rank_k;
    logic [TOT_W-1:0]   total;
    logic [N_W-1:0]     weight;
    logic               accept;
    logic               full;
    logic               out_load;

    logic                    div_start;
    logic signed [ACC_W-1:0] div_a;
    logic [TOT_W-1:0]        div_d;
    logic                    div_busy;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_q;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign full     = (fill_reg == N_W'(WINDOW));
    assign cand     = scan[0];
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // cell control
    assign ctrl.shift  = accept;
    assign ctrl.load   = (state_reg == ST_LOAD);
    assign ctrl.rotate = (state_reg == ST_SCAN);

    // chain of cells: newest sample at cell 0, scan ring rotates towards 0
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        assign held_vec[i] = (N_W'(i) < fill_reg);
        wsf_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .held     (held_vec[i]),
            .win_in   ((i == 0) ? sample : win[(i == 0) ? 0 : i - 1]),
            .win_out  (win[i]),
            .scan_in  (scan[(i + 1) % WINDOW]),
            .scan_out (scan[i]),
            .cand     (cand),
            .lt       (lt_vec[i]),
            .le       (le_vec[i])
        );
    end

    // rank counts, median index and weight of the current candidate
    assign lt_cnt = N_W'($countones(lt_vec));
    assign le_cnt = N_W'($countones(le_vec));
    assign rank_k = fill_reg >> 1;
    assign weight = fill_reg - t_reg;
    assign total  = TOT_W'((TOT_W + 1)'(fill_reg) * (TOT_W + 1)'(fill_reg + 1'b1) >> 1);
    assign acc_next = (t_reg < fill_reg)
                    ? acc_reg + ACC_W'(cand * $signed({1'b0, weight}))
                    : acc_reg;

    // window bookkeeping on a new item
    assign fill_next = full ? fill_reg : fill_reg + 1'b1;
    assign sum_next  = sum_reg + SUM_W'(sample)
                     - (full ? SUM_W'(win[WINDOW-1]) : SUM_W'(0));

    // divider operands
    assign div_start = ((state_reg == ST_LOAD) && (cur_mode_reg != MODE_MEDIAN)
                        && (cur_mode_reg != MODE_WEIGHTED))
                    || ((state_reg == ST_SCAN) && (cur_mode_reg == MODE_WEIGHTED)
                        && (t_reg == N_W'(WINDOW - 1)));
    assign div_a = (state_reg == ST_LOAD) ? ACC_W'(sum_reg) : acc_next;
    assign div_d = (state_reg == ST_LOAD) ? TOT_W'(fill_reg) : total;

    wsf_div #(
        .A_W (ACC_W),
        .D_W (TOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_d),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer, window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RESET;
            cur_mode_reg  <= MODE_RESET;
            fill_reg      <= '0;
            sum_reg       <= '0;
            t_reg         <= '0;
            acc_reg       <= '0;
            found_reg     <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_held_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            // output valid: set on a load, cleared when taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        fill_reg     <= fill_next;
                        sum_reg      <= sum_next;
                        cur_mode_reg <= mode_reg;
                        if ((mode_reg == MODE_MEDIAN) && (fill_next < N_W'(MEDIAN_MIN)))
                        begin
                            res_reg   <= sample;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    t_reg     <= '0;
                    acc_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= div_start ? ST_DIV : ST_SCAN;
                end
                ST_SCAN:
                begin
                    t_reg   <= t_reg + 1'b1;
                    acc_reg <= acc_next;
                    if (!found_reg && (t_reg < fill_reg) && (lt_cnt <= rank_k)
                        && (le_cnt > rank_k))
                    begin
                        found_reg <= 1'b1;
                        res_reg   <= cand;
                    end
                    if (t_reg == N_W'(WINDOW - 1))
                    begin
                        state_reg <= div_start ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= div_q[SAMPLE_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_val_reg   <= res_reg;
                        out_held_reg  <= HELD_W'(fill_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_val_reg;
    assign samples_held   = out_held_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= N_W'(WINDOW))
        else $error("fill count beyond window");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (fill_reg != '0))
        else $error("result with empty window");

endmodule : windowed_sample_filter

`default_nettype wire

// File: tb/windowed_sample_filter_tb.sv
// ----------------------------------------------------------------------------
// windowed_sample_filter_tb: self-checking bench for the windowed sample filter
// Directed table then random samples under several idling phases; each item
// is predicted by a behavioural window model and compared on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_sample_filter_tb;
    import wsf_pkg::*;

    localparam int WINDOW      = 16;
    localparam int WDOG_LIMIT  = 20000;
    localparam int SETTLE      = 200;

    // idling per phase, percent of cycles
    localparam int unsigned IDLE_TAB  [4] = '{0, 87, 0, 6};
    localparam int unsigned STALL_TAB [4] = '{0, 0, 87, 6};

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [MODE_W-1:0]       cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [23:0]      sample = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [23:0]      filtered_value;
    logic [HELD_W-1:0]       samples_held;

    windowed_sample_filter #(.WINDOW(WINDOW)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .samples_held   (samples_held)
    );

    always #5 clk = ~clk;

    // expected result of one item
    typedef struct {
        logic signed [23:0] value;
        logic [HELD_W-1:0]  held;
    } filt_res_t;

    // behavioural copy of the filter state
    sample_t      win_q [WINDOW];
    int unsigned  wr_ptr;
    int unsigned  n_held;
    longint       win_sum;
    mode_t        cur_mode;

    filt_res_t    expected_q [$];
    int           n_fail = 0;
    int           n_items = 0;
    int           n_results = 0;
    int           wdog = 0;
    int unsigned  in_idle_pct = 0;
    int unsigned  out_stall_pct = 0;
    bit           sim_done = 1'b0;

    // directed rows: sample, mode, use typed value, typed value
    typedef struct {
        logic signed [23:0] smp;
        mode_t              mode;
        bit                 typed;
        logic signed [23:0] val;
    } drow_t;

    function automatic filt_res_t filter_sample(sample_t s);
        filt_res_t r;
        longint    res;
        longint    acc;
        longint    tot;
        sample_t   srt [WINDOW];
        sample_t   key;
        int        j;
        int unsigned slot;
        if (n_held >= WINDOW)
            win_sum -= win_q[wr_ptr];
        else
            n_held++;
        win_q[wr_ptr] = s;
        win_sum += s;
        wr_ptr = (wr_ptr + 1) % WINDOW;
        if (cur_mode == MODE_MEDIAN)
        begin
            if (n_held < MEDIAN_MIN)
                res = s;
            else
            begin
                // insertion sort over the held slots
                for (int i = 0; i < WINDOW; i++)
                    srt[i] = win_q[i];
                for (int i = 1; i < n_held; i++)
                begin
                    key = srt[i];
                    j = i;
                    while (j > 0 && srt[j-1] > key)
                    begin
                        srt[j] = srt[j-1];
                        j--;
                    end
                    srt[j] = key;
                end
                res = srt[n_held/2];
            end
        end
        else if (cur_mode == MODE_WEIGHTED)
        begin
            acc = 0;
            tot = 0;
            for (int i = 0; i < n_held; i++)
            begin
                slot = (wr_ptr + WINDOW - 1 - i) % WINDOW;
                acc += longint'(win_q[slot]) * (n_held - i);
                tot += n_held - i;
            end
            res = acc / tot;
        end
        else
            res = win_sum / longint'(n_held);
        r.value = res[23:0];
        r.held  = n_held[HELD_W-1:0];
        return r;
    endfunction

    // prediction without disturbing state
    function automatic filt_res_t filter_sample_peek(sample_t s);
        sample_t     sv_q [WINDOW];
        int unsigned sv_p, sv_n;
        longint      sv_s;
        filt_res_t   r;
        sv_q = win_q; sv_p = wr_ptr; sv_n = n_held; sv_s = win_sum;
        r = filter_sample(s);
        win_q = sv_q; wr_ptr = sv_p; n_held = sv_n; win_sum = sv_s;
        return r;
    endfunction

    // mode write at a falling edge while idle
    task automatic write_mode(mode_t m);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        cur_mode  = m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // send one item, optional idle gap first; valid stays up between items
    task automatic send_item(sample_t s);
        while (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(filter_sample(s));
        n_items++;
        @(negedge clk);
    endtask

    // receiver: random stall, check on accept
    always @(negedge clk)
    begin
        if (!sim_done)
            out_ready <= !(out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        filt_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result %0d/%0d with nothing expected",
                         $time, filtered_value, samples_held);
                n_fail++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (filtered_value !== e.value)
                begin
                    $display("%0t: filtered_value expected %0d actual %0d",
                             $time, e.value, filtered_value);
                    n_fail++;
                end
                if (samples_held !== e.held)
                begin
                    $display("%0t: samples_held expected %0d actual %0d",
                             $time, e.held, samples_held);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && expected_q.size() == 0))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("** windowed_sample_filter: FAILED **");
            $finish;
        end
    end

    // a directed row also checks its typed value against the predictor
    task automatic run_directed();
        drow_t rows [$];
        filt_res_t p;
        rows = '{
            '{24'sh000000, MODE_MEDIAN, 1, 24'sh000000},  // first after reset
            '{24'sh7FFFFF, MODE_MEDIAN, 1, 24'sh7FFFFF},  // passthrough, max
            '{24'sh800000, MODE_MEDIAN, 0, 24'sh0},
            '{24'sh000001, MODE_MEDIAN, 0, 24'sh0},
            '{24'shFFFFFF, MODE_MEDIAN, 0, 24'sh0}
        };
        for (int i = 0; i < rows.size(); i++)
        begin
            p = filter_sample_peek(rows[i].smp);
            if (rows[i].typed && p.value !== rows[i].val)
            begin
                $display("%0t: table row %0d expected %0d actual %0d",
                         $time, i, rows[i].val, p.value);
                n_fail++;
            end
            send_item(rows[i].smp);
        end
        // send extremes in every mode, unused code included
        for (int m = 0; m < 4; m++)
        begin
            wait_drained();
            write_mode(mode_t'(m));
            for (int k = 0; k < 5; k++)
                send_item((k % 2) ? 24'sh7FFFFF : 24'sh800000);
        end
    endtask

    function automatic sample_t rand_sample();
        unique case ($urandom_range(3, 0))
            0: return sample_t'($urandom);
            1: return sample_t'($urandom_range(64, 0)) - 24'sd32;
            2: return $urandom_range(1, 0) ? 24'sh7FFFFF - $urandom_range(8, 0)
                                            : 24'sh800000 + $urandom_range(8, 0);
            default: return sample_t'($urandom_range(4000, 0)) + 24'sd16000;
        endcase
    endfunction

    initial
    begin
        for (int i = 0; i < WINDOW; i++)
            win_q[i] = '0;
        wr_ptr = 0; n_held = 0; win_sum = 0; cur_mode = MODE_RESET;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // random phases: mode and idling change between phases
        for (int ph = 0; ph < 20; ph++)
        begin
            wait_drained();
            write_mode(mode_t'($urandom_range(3, 0)));
            in_idle_pct   = IDLE_TAB[ph % 4];
            out_stall_pct = STALL_TAB[ph % 4];
            for (int k = 0; k < 100; k++)
                send_item(rand_sample());
        end
        wait_drained();
        sim_done = 1'b1;

        $display("Covered %0d items, %0d results, all four mode codes and four idling phases.",
                 n_items, n_results);
        if (n_fail == 0 && expected_q.size() == 0)
            $display("** windowed_sample_filter: PASSED **");
        else
            $display("** windowed_sample_filter: FAILED **");
        $finish;
    end

endmodule
